// ===== design/ksp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksp_pkg
// Shared types and constants of the keyed slot pool: transaction payloads,
// slot states, result codes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package ksp_pkg;

  // Default pool depth
  localparam int SLOTS_DEFAULT = 16;

  // Field widths fixed by the transaction format
  localparam int OP_W    = 2;
  localparam int KEY_W   = 64;
  localparam int IDX_W   = 4;
  localparam int RES_W   = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

  // Result status codes
  localparam logic [RES_W-1:0] RES_OK       = 2'd0;
  localparam logic [RES_W-1:0] RES_FULL     = 2'd1;
  localparam logic [RES_W-1:0] RES_MISMATCH = 2'd2;
  localparam logic [RES_W-1:0] RES_NOT_USED = 2'd3;

  // Per-slot state
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_FREE  = 2'd1,
    SLOT_USED  = 2'd2
  } slot_state_t;

  // Request transaction
  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key_hash;
    logic [IDX_W-1:0] slot_index;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    logic             reused;
    logic [RES_W-1:0] status;
  } rsp_t;

  // Controller state
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SCAN,
    CS_LOOKUP,
    CS_SETTLE,
    CS_FINISH
  } ctrl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // capture request, clear scan trackers
    logic scan_rd;    // read slot at scan pointer, advance pointer
    logic lookup_rd;  // read slot addressed by the request
    logic commit;     // update pool, load response register
  } ksp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic req_acquire;  // incoming request is an acquire
    logic ptr_last;     // scan pointer is at the last slot
    logic out_free;     // response register can take a new result
  } ksp_sts_t;

endpackage

// ===== design/ksp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksp_ctrl
// Sequencer for the slot pool: accepts one transaction, runs either a full
// scan or a single lookup, then commits when the response register is free.
// ----------------------------------------------------------------------------
module ksp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ksp_pkg::ksp_sts_t sts,
  output ksp_pkg::ksp_cmd_t cmd
);

  ksp_pkg::ctrl_state_t state;
  ksp_pkg::ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ksp_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ksp_pkg::CS_IDLE: begin
        if (req_valid) begin
          state_next = sts.req_acquire ? ksp_pkg::CS_SCAN : ksp_pkg::CS_LOOKUP;
        end
      end
      ksp_pkg::CS_SCAN: begin
        if (sts.ptr_last) begin
          state_next = ksp_pkg::CS_SETTLE;
        end
      end
      ksp_pkg::CS_LOOKUP: begin
        state_next = ksp_pkg::CS_SETTLE;
      end
      ksp_pkg::CS_SETTLE: begin
        state_next = ksp_pkg::CS_FINISH;
      end
      ksp_pkg::CS_FINISH: begin
        if (sts.out_free) begin
          state_next = ksp_pkg::CS_IDLE;
        end
      end
      default: begin
        state_next = ksp_pkg::CS_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    req_stall     = (state != ksp_pkg::CS_IDLE);
    cmd.load      = (state == ksp_pkg::CS_IDLE) && req_valid;
    cmd.scan_rd   = (state == ksp_pkg::CS_SCAN);
    cmd.lookup_rd = (state == ksp_pkg::CS_LOOKUP);
    cmd.commit    = (state == ksp_pkg::CS_FINISH) && sts.out_free;
  end

endmodule

// ===== design/ksp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksp_datapath
// Key memory, slot state flops, scan trackers, result logic and the
// response register of the slot pool.
// ----------------------------------------------------------------------------
module ksp_datapath #(
  parameter int SLOTS = ksp_pkg::SLOTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  ksp_pkg::req_t     req,
  input  ksp_pkg::ksp_cmd_t cmd,
  output ksp_pkg::ksp_sts_t sts,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ksp_pkg::rsp_t     rsp
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Captured request
  logic [ksp_pkg::OP_W-1:0]  op_r;
  logic [ksp_pkg::KEY_W-1:0] key_r;
  logic [ksp_pkg::IDX_W-1:0] idx_r;

  // Storage: keys in memory, states in resettable flops
  logic [ksp_pkg::KEY_W-1:0] key_mem [SLOTS];
  ksp_pkg::slot_state_t      slot_state [SLOTS];

  // Read stage
  logic [SLOT_W-1:0]         ptr;
  logic [SLOT_W-1:0]         rd_addr;
  logic                      rd_en;
  logic [ksp_pkg::KEY_W-1:0] rd_key;
  ksp_pkg::slot_state_t      rd_state;
  logic [SLOT_W-1:0]         rd_slot;
  logic                      rd_valid;
  logic [ksp_pkg::KEY_W-1:0] key_eff;

  // Scan trackers
  logic              hit_found;
  logic [SLOT_W-1:0] hit_slot;
  logic              empty_found;
  logic [SLOT_W-1:0] empty_slot;

  // Commit decisions
  logic                       in_range;
  logic                       mem_we;
  logic                       state_we;
  logic [SLOT_W-1:0]          state_waddr;
  ksp_pkg::slot_state_t       state_wval;
  ksp_pkg::rsp_t              res;

  // Status to controller
  always_comb begin
    sts.req_acquire = (req.operation == ksp_pkg::OP_ACQUIRE);
    sts.ptr_last    = (ptr == SLOT_W'(SLOTS - 1));
    sts.out_free    = !rsp_valid || !rsp_stall;
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= req.operation;
      key_r <= req.key_hash;
      idx_r <= req.slot_index;
    end
  end

  // Scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.load) begin
      ptr <= '0;
    end else if (cmd.scan_rd) begin
      ptr <= ptr + SLOT_W'(1);
    end
  end

  assign rd_en   = cmd.scan_rd || cmd.lookup_rd;
  assign rd_addr = cmd.scan_rd ? ptr : SLOT_W'(idx_r);

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[empty_slot] <= key_r;
    end
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
    end
  end

  // Slot state flops
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] <= ksp_pkg::SLOT_EMPTY;
      end
    end else if (state_we) begin
      slot_state[state_waddr] <= state_wval;
    end
  end

  // Registered state read alongside the key read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_state <= slot_state[rd_addr];
      rd_slot  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  // Never-claimed slots hold key zero
  assign key_eff = (rd_state == ksp_pkg::SLOT_EMPTY) ? '0 : rd_key;

  // Scan trackers: lowest free slot with matching key, lowest empty slot
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else if (rd_valid && (op_r == ksp_pkg::OP_ACQUIRE)) begin
      if (!hit_found && (rd_state == ksp_pkg::SLOT_FREE) && (rd_key == key_r)) begin
        hit_found <= 1'b1;
        hit_slot  <= rd_slot;
      end
      if (!empty_found && (rd_state == ksp_pkg::SLOT_EMPTY)) begin
        empty_found <= 1'b1;
        empty_slot  <= rd_slot;
      end
    end
  end

  assign in_range = (32'(idx_r) < SLOTS);

  // Result and pool update
  always_comb begin
    mem_we            = 1'b0;
    state_we          = 1'b0;
    state_waddr       = SLOT_W'(idx_r);
    state_wval        = ksp_pkg::SLOT_USED;
    res.granted_index = idx_r;
    res.reused        = 1'b0;
    res.status        = ksp_pkg::RES_OK;
    case (op_r)
      ksp_pkg::OP_ACQUIRE: begin
        if (hit_found) begin
          state_we          = cmd.commit;
          state_waddr       = hit_slot;
          res.granted_index = ksp_pkg::IDX_W'(hit_slot);
          res.reused        = 1'b1;
        end else if (empty_found) begin
          mem_we            = cmd.commit;
          state_we          = cmd.commit;
          state_waddr       = empty_slot;
          res.granted_index = ksp_pkg::IDX_W'(empty_slot);
        end else begin
          res.granted_index = '0;
          res.status        = ksp_pkg::RES_FULL;
        end
      end
      ksp_pkg::OP_RELEASE: begin
        if (!in_range) begin
          res.status = ksp_pkg::RES_NOT_USED;
        end else if (key_eff != key_r) begin
          res.status = ksp_pkg::RES_MISMATCH;
        end else if (rd_state == ksp_pkg::SLOT_EMPTY) begin
          res.status = ksp_pkg::RES_NOT_USED;
        end else begin
          state_we   = cmd.commit;
          state_wval = ksp_pkg::SLOT_FREE;
        end
      end
      ksp_pkg::OP_QUERY: begin
        if (!in_range) begin
          res.status = ksp_pkg::RES_NOT_USED;
        end else if (key_eff != key_r) begin
          res.status = ksp_pkg::RES_MISMATCH;
        end else if (rd_state != ksp_pkg::SLOT_USED) begin
          res.status = ksp_pkg::RES_NOT_USED;
        end
      end
      default: begin
        // no-op: echo index, status ok
      end
    endcase
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= res;
    end
  end

endmodule

// ===== design/keyed_slot_pool_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_pool_top
// Pool of keyed slots: acquire by key (reuse or claim), release and query.
//
//   channel | signals                  | direction | payload
//   --------+--------------------------+-----------+---------------------
//   req     | req_valid / req_stall    | in        | ksp_pkg::req_t
//   rsp     | rsp_valid / rsp_stall    | out       | ksp_pkg::rsp_t
//
// Acquire passes through scan, settle, commit and idle; the scan
// reads one slot per cycle through the single read port of the key memory.
// Release, query and the no-op pass through lookup, settle, commit and idle.
// Reset clears slot states at once; no clearing pass, keys of never-claimed
// slots read as zero. A stalled response holds; the next request is taken
// while it waits, and its commit waits only for the response register.
// ----------------------------------------------------------------------------
module keyed_slot_pool_top #(
  parameter int SLOTS = ksp_pkg::SLOTS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ksp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ksp_pkg::rsp_t rsp
);

  ksp_pkg::ksp_cmd_t cmd;
  ksp_pkg::ksp_sts_t sts;

  // Sequencer
  ksp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and result logic
  ksp_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== design/ksp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksp_checker
// Port-level checks for the keyed slot pool, bound to the top level.
// ----------------------------------------------------------------------------
module ksp_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input ksp_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ksp_pkg::rsp_t rsp
);

  // Stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // One transaction in flight: an accept closes the request side
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request side open right after an accept");

  // Reuse is only reported on success
  a_reuse_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.reused |-> rsp.status == ksp_pkg::RES_OK)
    else $error("reuse flagged with a failing status");

  // Pool full answers index zero and no reuse
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ksp_pkg::RES_FULL) |->
      (rsp.granted_index == '0) && !rsp.reused)
    else $error("pool-full response carries an index");

endmodule

bind keyed_slot_pool_top ksp_checker u_ksp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
